>>> design/vmm_pkg.sv
// ----------------------------------------------------------------------------
// vmm_pkg: shared types and floating-point helpers
// Lane count, lane control struct, and the single-precision round/pack
// and add functions used by the multiplier and the lane accumulators.
// ----------------------------------------------------------------------------
package vmm_pkg;

  localparam int LANES = 8;
  localparam logic [31:0] CANON_NAN = 32'h7FC0_0000;

  typedef struct packed {
    logic en;          // pipeline advances this cycle
    logic acc_valid;   // a product reaches the accumulators
    logic acc_last;    // that product closes the column block
  } lane_ctl_t;

  // Normalizes a nonnegative 48-bit magnitude p whose value is
  // p * 2^(ep - 127 - 46), then rounds to nearest even and packs it.
  // Results that fall below the normal range become subnormals.
  function automatic logic [31:0] fp_round_pack(input logic sign,
                                                input logic signed [10:0] ep,
                                                input logic [47:0] p);
    logic [5:0] lz;
    logic found;
    logic [47:0] n;
    logic signed [10:0] r;
    logic [10:0] sh;
    logic [47:0] m;
    logic sticky;
    logic [23:0] keep;
    logic rbit;
    logic inc;
    logic [7:0] exp8;
    logic [30:0] body;
    lz = '0;
    found = 1'b0;
    for (int i = 47; i >= 0; i--) begin
      if (!found && p[i]) begin
        lz = 6'(47 - i);
        found = 1'b1;
      end
    end
    n = p << lz;
    r = ep + 11'sd1 - $signed({5'b0, lz});
    if (r < 11'sd1) begin
      sh = 11'(11'sd1 - r);
      if (sh > 11'd47) begin
        m = '0;
        sticky = |n;
      end else begin
        m = n >> sh[5:0];
        sticky = |(n & ~({48{1'b1}} << sh[5:0]));
      end
      exp8 = '0;
    end else begin
      sh = '0;
      m = n;
      sticky = 1'b0;
      exp8 = r[7:0];
    end
    keep = m[47:24];
    rbit = m[23];
    sticky = sticky | (|m[22:0]);
    inc = rbit & (sticky | keep[0]);
    body = {exp8, keep[22:0]} + 31'(inc);
    if (p == '0) begin
      fp_round_pack = {sign, 31'b0};
    end else if (r > 11'sd254) begin
      fp_round_pack = {sign, 8'hFF, 23'b0};
    end else begin
      fp_round_pack = {sign, body};
    end
  endfunction

  // Single-precision add, round to nearest even, canonical NaN out.
  function automatic logic [31:0] fp_add(input logic [31:0] x, input logic [31:0] y);
    logic nan_x, nan_y, inf_x, inf_y;
    logic [31:0] bg, sm;
    logic [23:0] mb, ms;
    logic [7:0] eb, es, d;
    logic [26:0] yfull, ya;
    logic st;
    logic [27:0] xx, yy, s;
    nan_x = (x[30:23] == 8'hFF) && (x[22:0] != '0);
    nan_y = (y[30:23] == 8'hFF) && (y[22:0] != '0);
    inf_x = (x[30:23] == 8'hFF) && (x[22:0] == '0);
    inf_y = (y[30:23] == 8'hFF) && (y[22:0] == '0);
    if (y[30:0] > x[30:0]) begin
      bg = y;
      sm = x;
    end else begin
      bg = x;
      sm = y;
    end
    mb = {bg[30:23] != '0, bg[22:0]};
    ms = {sm[30:23] != '0, sm[22:0]};
    eb = (bg[30:23] == '0) ? 8'd1 : bg[30:23];
    es = (sm[30:23] == '0) ? 8'd1 : sm[30:23];
    d = eb - es;
    yfull = {ms, 3'b0};
    if (d > 8'd26) begin
      ya = '0;
      st = |yfull;
    end else begin
      ya = yfull >> d[4:0];
      st = |(yfull & ~({27{1'b1}} << d[4:0]));
    end
    xx = {1'b0, mb, 3'b0};
    yy = {1'b0, ya[26:1], ya[0] | st};
    s = (bg[31] == sm[31]) ? (xx + yy) : (xx - yy);
    if (nan_x || nan_y || (inf_x && inf_y && (x[31] != y[31]))) begin
      fp_add = CANON_NAN;
    end else if (inf_x) begin
      fp_add = x;
    end else if (inf_y) begin
      fp_add = y;
    end else if (s == '0) begin
      fp_add = {bg[31] & sm[31], 31'b0};
    end else begin
      fp_add = fp_round_pack(bg[31], $signed({3'b0, eb}), {s, 20'b0});
    end
  endfunction

endpackage

>>> design/vmm_in_if.sv
// ----------------------------------------------------------------------------
// vmm_in_if: input channel
// One item: a vector element and the matrix elements of one row chunk.
// ----------------------------------------------------------------------------
interface vmm_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] a_value;
  logic [31:0] b_lane0;
  logic [31:0] b_lane1;
  logic [31:0] b_lane2;
  logic [31:0] b_lane3;
  logic [31:0] b_lane4;
  logic [31:0] b_lane5;
  logic [31:0] b_lane6;
  logic [31:0] b_lane7;

  modport source (output valid, a_value, b_lane0, b_lane1, b_lane2, b_lane3,
                  b_lane4, b_lane5, b_lane6, b_lane7, input ready);
  modport sink (input valid, a_value, b_lane0, b_lane1, b_lane2, b_lane3,
                b_lane4, b_lane5, b_lane6, b_lane7, output ready);
endinterface

>>> design/vmm_out_if.sv
// ----------------------------------------------------------------------------
// vmm_out_if: result channel
// One item: the eight finished dot products of a column block.
// ----------------------------------------------------------------------------
interface vmm_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] c_lane0;
  logic [31:0] c_lane1;
  logic [31:0] c_lane2;
  logic [31:0] c_lane3;
  logic [31:0] c_lane4;
  logic [31:0] c_lane5;
  logic [31:0] c_lane6;
  logic [31:0] c_lane7;

  modport source (output valid, c_lane0, c_lane1, c_lane2, c_lane3,
                  c_lane4, c_lane5, c_lane6, c_lane7, input ready);
  modport sink (input valid, c_lane0, c_lane1, c_lane2, c_lane3,
                c_lane4, c_lane5, c_lane6, c_lane7, output ready);
endinterface

>>> design/vmm_fmul.sv
// ----------------------------------------------------------------------------
// vmm_fmul: two-stage single-precision multiplier
// Stage one forms the 48-bit mantissa product and class flags, stage two
// normalizes and rounds.
// ----------------------------------------------------------------------------
module vmm_fmul (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [31:0] prod
);
  import vmm_pkg::*;

  logic                zero_a, zero_b, inf_a, inf_b, nan_a, nan_b;
  logic [23:0]         ma, mb;
  logic [7:0]          ea, eb;
  logic                p_sign, p_nan, p_inf, p_zero;
  logic [47:0]         p_mant;
  logic signed [10:0]  p_exp;
  logic [31:0]         rounded;

  always_comb begin
    zero_a = (a[30:0] == '0);
    zero_b = (b[30:0] == '0);
    inf_a  = (a[30:23] == 8'hFF) && (a[22:0] == '0);
    inf_b  = (b[30:23] == 8'hFF) && (b[22:0] == '0);
    nan_a  = (a[30:23] == 8'hFF) && (a[22:0] != '0);
    nan_b  = (b[30:23] == 8'hFF) && (b[22:0] != '0);
    ma = {a[30:23] != '0, a[22:0]};
    mb = {b[30:23] != '0, b[22:0]};
    ea = (a[30:23] == '0) ? 8'd1 : a[30:23];
    eb = (b[30:23] == '0) ? 8'd1 : b[30:23];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_sign <= a[31] ^ b[31];
      p_nan  <= nan_a | nan_b | (inf_a & zero_b) | (zero_a & inf_b);
      p_inf  <= inf_a | inf_b;
      p_zero <= zero_a | zero_b;
      p_mant <= 48'(ma) * 48'(mb);
      p_exp  <= $signed({3'b0, ea}) + $signed({3'b0, eb}) - 11'sd127;
    end
  end

  always_comb begin
    priority if (p_nan) begin
      rounded = CANON_NAN;
    end else if (p_inf) begin
      rounded = {p_sign, 8'hFF, 23'b0};
    end else if (p_zero) begin
      rounded = {p_sign, 31'b0};
    end else begin
      rounded = fp_round_pack(p_sign, p_exp, p_mant);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= rounded;
    end
  end
endmodule

>>> design/vmm_lane.sv
// ----------------------------------------------------------------------------
// vmm_lane: one multiply-accumulate lane
// Rounded product, then rounded add into the lane accumulator, which is
// cleared when a column block closes.
// ----------------------------------------------------------------------------
module vmm_lane (
  input  logic              clk,
  input  logic              rst,
  input  vmm_pkg::lane_ctl_t ctl,
  input  logic [31:0]       a,
  input  logic [31:0]       b,
  output logic [31:0]       sum
);
  import vmm_pkg::*;

  logic [31:0] prod;
  logic [31:0] acc;

  vmm_fmul u_fmul (
    .clk  (clk),
    .en   (ctl.en),
    .a    (a),
    .b    (b),
    .prod (prod)
  );

  assign sum = fp_add(acc, prod);

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (ctl.en && ctl.acc_valid) begin
      acc <= ctl.acc_last ? 32'h0 : sum;
    end
  end
endmodule

>>> design/vector_matrix_mac_lanes.sv
// ----------------------------------------------------------------------------
// vector_matrix_mac_lanes: eight-lane single-precision vector-matrix MAC
// Accumulates one column block of C = A * B and emits the eight sums.
// ----------------------------------------------------------------------------
// Usage: the feeder sends one item per matrix row on the feed channel: the
// vector element and the eight matrix elements of that row in the current
// column block. After row_count items (a value of 0 acts as 1) the block
// sends one item on the result channel with the eight dot products and
// clears its accumulators. row_count is written through cfg_we/cfg_data and
// takes effect on the next row; the user must write it only while the block
// is idle, which the block itself does not enforce. Throughput is one item
// per cycle unless the pipeline holds: each lane has a two-stage multiplier
// and a combinational add into its accumulator, which closes the only loop.
// Reset (rst, synchronous) empties the pipeline, zeroes the accumulators and
// the row counter and sets row_count to 1.
// A held result does not block the feed; only when a block-closing row
// reaches the accumulators while the result register is still full does the
// pipeline hold and feed.ready drop until the result is taken.
// ----------------------------------------------------------------------------
module vector_matrix_mac_lanes (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_data,
  vmm_in_if.sink      feed,
  vmm_out_if.source   result
);
  import vmm_pkg::*;

  logic [15:0]       row_count;
  logic [15:0]       rows_seen;
  logic              blk_end;
  logic              accept;
  logic              en;

  // Input stage registers.
  logic              v1, e1;
  logic [31:0]       a1;
  logic [31:0]       b1 [LANES];
  // Tracking of the two multiplier stages.
  logic              v2, e2, v3, e3;

  lane_ctl_t         ctl;
  logic [31:0]       sums [LANES];
  logic [31:0]       held [LANES];
  logic              out_valid;

  // The whole pipeline moves unless a closing row would overwrite a result
  // that the receiver has not taken yet.
  assign en = !(v3 && e3 && out_valid && !result.ready);
  assign feed.ready = en;
  assign accept = feed.valid && en;

  // A block closes on the row where rows_seen + 1 reaches row_count.
  assign blk_end = ({1'b0, rows_seen} + 17'd1) >= {1'b0, row_count};

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= 16'd1;
    end else if (cfg_we) begin
      row_count <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_seen <= '0;
    end else if (accept) begin
      rows_seen <= blk_end ? 16'd0 : rows_seen + 16'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v1 <= feed.valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e1 <= blk_end;
      e2 <= e1;
      e3 <= e2;
      a1 <= feed.a_value;
      b1[0] <= feed.b_lane0;
      b1[1] <= feed.b_lane1;
      b1[2] <= feed.b_lane2;
      b1[3] <= feed.b_lane3;
      b1[4] <= feed.b_lane4;
      b1[5] <= feed.b_lane5;
      b1[6] <= feed.b_lane6;
      b1[7] <= feed.b_lane7;
    end
  end

  assign ctl = '{en: en, acc_valid: v3, acc_last: e3};

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    vmm_lane u_lane (
      .clk (clk),
      .rst (rst),
      .ctl (ctl),
      .a   (a1),
      .b   (b1[g]),
      .sum (sums[g])
    );
  end

  // Merge stage: the closing row's lane sums land in one result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en && v3 && e3) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en && v3 && e3) begin
      held <= sums;
    end
  end

  assign result.valid   = out_valid;
  assign result.c_lane0 = held[0];
  assign result.c_lane1 = held[1];
  assign result.c_lane2 = held[2];
  assign result.c_lane3 = held[3];
  assign result.c_lane4 = held[4];
  assign result.c_lane5 = held[5];
  assign result.c_lane6 = held[6];
  assign result.c_lane7 = held[7];

  a_hold_on_full: assert property (@(posedge clk) disable iff (rst)
    (v3 && e3 && out_valid && !result.ready) |-> !feed.ready)
    else $error("closing row advanced over an untaken result");

  a_close_loads: assert property (@(posedge clk) disable iff (rst)
    (v3 && e3 && en) |=> out_valid)
    else $error("closing row did not load the result register");

  a_rise_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(v3 && e3))
    else $error("result appeared without a closing row");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !feed.ready |-> out_valid)
    else $error("feed stalled with an empty result register");
endmodule
